FILE: hdl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CPS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CPS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/cps_pkg.sv
`timescale 1ns / 1ps
package cps_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TR_RD,
		ST_TR_MUL,
		ST_TR_WR,
		ST_E_RDA,
		ST_E_RDB,
		ST_E_DIF,
		ST_E_MUL,
		ST_E_CHK,
		ST_E_DIV,
		ST_E_SCL,
		ST_E_D2,
		ST_E_CMP,
		ST_C_DIF,
		ST_C_MUL,
		ST_C_SQ,
		ST_C_CHK,
		ST_C_DM,
		ST_C_DVI,
		ST_C_DV,
		ST_C_OUT,
		ST_DONE
	} state_t;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_POLY   = 2'd1;
	localparam logic [1:0] KIND_CIRCLE = 2'd2;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_CENTER = 2'd2;

	localparam logic [2:0] REG_KIND   = 3'd0;
	localparam logic [2:0] REG_COUNT  = 3'd1;
	localparam logic [2:0] REG_BODY_X = 3'd2;
	localparam logic [2:0] REG_BODY_Y = 3'd3;
	localparam logic [2:0] REG_COS    = 3'd4;
	localparam logic [2:0] REG_SIN    = 3'd5;
	localparam logic [2:0] REG_RADIUS = 3'd6;

	localparam int TR_STEPS  = 4;
	localparam int E_STEPS   = 4;
	localparam int T_BITS    = 16;
	localparam int SQ_STEPS  = 34;
	localparam int DIV_STEPS = 32;

endpackage

FILE: hdl/cps_ram.sv
`timescale 1ns / 1ps
module cps_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/closest_point_on_shape.sv
`timescale 1ns / 1ps
// channel  | dir | handshake         | payload
// s        | in  | s_tvalid/s_tready | tdata: vertex_slot, coord_x, coord_y; tuser: action
// m        | out | m_tvalid/m_tready | tdata: closest_x, closest_y; tuser: status
// cfg      | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a load is written to the vertex store when it is accepted; a query is worked on alone, one step per
// cycle, sharing one 33x33 multiplier; the divides and the root have their own shift-subtract logic
// polygon: every vertex is turned first, then every edge is checked, with a 16-step t divide where
// the projection falls inside the edge; circle: a 34-step root, then two 32-step divides
// reset clears control and configuration (cos resets to 65536); vertex store contents stay undefined until loaded
// the result waits in the output register while the next item is taken; a query that
// finishes while that register is still full waits in its last state
`include "assert_macros.svh"
module closest_point_on_shape
	import cps_pkg::*;
#(
	parameter int MAX_VERTICES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // vertex_slot[2:0], coord_x[34:3], coord_y[66:35], zero
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // closest_x[31:0], closest_y[63:32]
	output logic [1:0]  m_tuser,   // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = ($clog2(MAX_VERTICES + 1) > 4) ? $clog2(MAX_VERTICES + 1) : 4;

	function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
		logic signed [36:0] hi;
		logic signed [36:0] lo;
		hi = 37'sd2147483647;
		lo = -37'sd2147483648;
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [32:0] scale_rnd(input logic signed [65:0] p);
		logic [65:0] m;
		logic [65:0] q;
		m = p[65] ? $unsigned(-p) : $unsigned(p);
		q = (m + 66'd32768) >> 16;
		return p[65] ? -$signed(q[32:0]) : $signed(q[32:0]);
	endfunction

	state_t state_q, state_d;

	logic [1:0]         kind_q;
	logic [3:0]         vcount_q;
	logic signed [31:0] body_x_q, body_y_q;
	logic signed [17:0] cos_q, sin_q;
	logic [30:0]        radius_q;

	logic [AW-1:0] idx_q;
	logic [5:0]    cnt_q;
	logic          first_q;
	logic          axis_q;

	logic signed [31:0] px_q, py_q, ax_q, ay_q;
	logic signed [32:0] dx_q, dy_q, ex_q, ey_q;
	logic signed [51:0] accx_q, accy_q;
	logic signed [65:0] prod_q;
	logic [65:0]        len2_q;
	logic signed [66:0] dot_q;
	logic [66:0]        r_q;
	logic [16:0]        t_q;
	logic signed [32:0] cx_q, cy_q;
	logic [65:0]        d2_q, best_q;
	logic signed [31:0] res_x_q, res_y_q;
	logic [1:0]         res_st_q;
	logic [67:0]        sqn_q;
	logic [37:0]        rem_q;
	logic [33:0]        root_q;
	logic [34:0]        drem_q;
	logic [31:0]        dnum_q;
	logic [31:0]        quo_q;

	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	logic               s_acc;
	logic [CW-1:0]      n_use;
	logic               last;
	logic [AW-1:0]      j_idx;
	logic signed [32:0] mul_a, mul_b;

	logic          lv_we, lv_re;
	logic [AW-1:0] lv_waddr;
	logic [63:0]   lv_rdata;
	logic          wv_we, wv_re;
	logic [AW-1:0] wv_raddr;
	logic [63:0]   wv_wdata, wv_rdata;

	logic signed [36:0] tr_x, tr_y;
	logic [66:0]        r_dbl;
	logic [37:0]        sq_rem, sq_trial;
	logic [34:0]        dv_rem;
	logic [65:0]        prod_mag;
	logic signed [36:0] c_out;
	logic               out_free;

	assign s_acc    = s_tvalid && s_tready;
	assign n_use    = (CW'(vcount_q) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_q);
	assign last     = (CW'(idx_q) + CW'(1)) == n_use;
	assign j_idx    = last ? '0 : idx_q + AW'(1);
	assign out_free = !m_tvalid_q || m_tready;

	assign tr_x = 37'((accx_q + 52'sd32768) >>> 16) + 37'(body_x_q);
	assign tr_y = 37'((accy_q + 52'sd32768) >>> 16) + 37'(body_y_q);

	assign r_dbl    = {r_q[65:0], 1'b0};
	assign sq_rem   = {rem_q[35:0], sqn_q[67:66]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign dv_rem   = {drem_q[33:0], dnum_q[31]};
	assign prod_mag = prod_q[65] ? $unsigned(-prod_q) : $unsigned(prod_q);
	assign c_out    = 37'(axis_q ? body_y_q : body_x_q) +
		((axis_q ? dy_q[32] : dx_q[32]) ? -$signed({5'd0, quo_q}) : $signed({5'd0, quo_q}));

	cps_ram #(.WIDTH(64), .DEPTH(MAX_VERTICES)) u_local (
		.clk   (clk),
		.we    (lv_we),
		.waddr (lv_waddr),
		.wdata (s_tdata[66:3]),
		.re    (lv_re),
		.raddr (idx_q),
		.rdata (lv_rdata)
	);

	cps_ram #(.WIDTH(64), .DEPTH(MAX_VERTICES)) u_world (
		.clk   (clk),
		.we    (wv_we),
		.waddr (idx_q),
		.wdata (wv_wdata),
		.re    (wv_re),
		.raddr (wv_raddr),
		.rdata (wv_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc && s_tuser == ACT_QUERY) begin
					if (kind_q == KIND_POLY && n_use != '0) begin
						state_d = ST_TR_RD;
					end else if (kind_q == KIND_CIRCLE) begin
						state_d = ST_C_DIF;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_TR_RD:  state_d = ST_TR_MUL;
			ST_TR_MUL: if (cnt_q == 6'(TR_STEPS)) state_d = ST_TR_WR;
			ST_TR_WR:  state_d = last ? ST_E_RDA : ST_TR_RD;
			ST_E_RDA:  state_d = ST_E_RDB;
			ST_E_RDB:  state_d = ST_E_DIF;
			ST_E_DIF:  state_d = ST_E_MUL;
			ST_E_MUL:  if (cnt_q == 6'(E_STEPS)) state_d = ST_E_CHK;
			ST_E_CHK: begin
				if (len2_q == '0 || dot_q[66] || dot_q == '0 || dot_q[65:0] >= len2_q) begin
					state_d = ST_E_SCL;
				end else begin
					state_d = ST_E_DIV;
				end
			end
			ST_E_DIV:  if (cnt_q == 6'(T_BITS - 1)) state_d = ST_E_SCL;
			ST_E_SCL:  if (cnt_q == 6'd2) state_d = ST_E_D2;
			ST_E_D2:   if (cnt_q == 6'd2) state_d = ST_E_CMP;
			ST_E_CMP:  state_d = last ? ST_DONE : ST_E_RDA;
			ST_C_DIF:  state_d = ST_C_MUL;
			ST_C_MUL:  if (cnt_q == 6'd2) state_d = ST_C_SQ;
			ST_C_SQ:   if (cnt_q == 6'(SQ_STEPS - 1)) state_d = ST_C_CHK;
			ST_C_CHK:  state_d = (root_q == '0) ? ST_DONE : ST_C_DM;
			ST_C_DM:   state_d = ST_C_DVI;
			ST_C_DVI:  state_d = ST_C_DV;
			ST_C_DV:   if (cnt_q == 6'(DIV_STEPS - 1)) state_d = ST_C_OUT;
			ST_C_OUT:  state_d = axis_q ? ST_DONE : ST_C_DM;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs, memory ports and multiplier operands
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		cfg_ready = 1'b1;
		lv_we    = s_acc && s_tuser == ACT_LOAD &&
			(CW'(s_tdata[2:0]) < CW'(MAX_VERTICES));
		lv_waddr = AW'(s_tdata[2:0]);
		lv_re    = (state_q == ST_TR_RD);
		wv_we    = (state_q == ST_TR_WR);
		wv_wdata = {sat32(tr_y), sat32(tr_x)};
		wv_re    = (state_q == ST_E_RDA) || (state_q == ST_E_RDB);
		wv_raddr = (state_q == ST_E_RDB) ? j_idx : idx_q;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_TR_MUL: begin
				case (cnt_q)
					6'd0: begin mul_a = 33'(cos_q); mul_b = 33'($signed(lv_rdata[31:0])); end
					6'd1: begin mul_a = 33'(sin_q); mul_b = 33'($signed(lv_rdata[63:32])); end
					6'd2: begin mul_a = 33'(sin_q); mul_b = 33'($signed(lv_rdata[31:0])); end
					default: begin
						mul_a = 33'(cos_q);
						mul_b = 33'($signed(lv_rdata[63:32]));
					end
				endcase
			end
			ST_E_MUL: begin
				case (cnt_q)
					6'd0: begin mul_a = dx_q; mul_b = dx_q; end
					6'd1: begin mul_a = dy_q; mul_b = dy_q; end
					6'd2: begin mul_a = ex_q; mul_b = dx_q; end
					default: begin mul_a = ey_q; mul_b = dy_q; end
				endcase
			end
			ST_E_SCL: begin
				mul_a = (cnt_q == 6'd0) ? dx_q : dy_q;
				mul_b = $signed({16'd0, t_q});
			end
			ST_E_D2: begin
				mul_a = (cnt_q == 6'd0) ? 33'(cx_q - 33'(px_q)) : 33'(cy_q - 33'(py_q));
				mul_b = mul_a;
			end
			ST_C_MUL: begin
				mul_a = (cnt_q == 6'd0) ? dx_q : dy_q;
				mul_b = mul_a;
			end
			ST_C_DM: begin
				mul_a = axis_q ? dy_q : dx_q;
				mul_b = $signed({2'b00, radius_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			first_q  <= 1'b0;
			axis_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			kind_q   <= KIND_NONE;
			vcount_q <= '0;
			body_x_q <= '0;
			body_y_q <= '0;
			cos_q    <= 18'sd65536;
			sin_q    <= '0;
			radius_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 6'd1;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_KIND:   kind_q   <= cfg_data[1:0];
					REG_COUNT:  vcount_q <= cfg_data[3:0];
					REG_BODY_X: body_x_q <= $signed(cfg_data);
					REG_BODY_Y: body_y_q <= $signed(cfg_data);
					REG_COS:    cos_q    <= $signed(cfg_data[17:0]);
					REG_SIN:    sin_q    <= $signed(cfg_data[17:0]);
					REG_RADIUS: radius_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (state_q == ST_IDLE) begin
				idx_q   <= '0;
				first_q <= 1'b1;
				axis_q  <= 1'b0;
			end else if (state_q == ST_TR_WR || state_q == ST_E_CMP) begin
				idx_q <= j_idx;
			end
			if (state_q == ST_E_CMP) first_q <= 1'b0;
			if (state_q == ST_C_OUT) axis_q <= 1'b1;
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {res_y_q, res_x_q};
			m_tuser_q <= res_st_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				px_q     <= $signed(s_tdata[34:3]);
				py_q     <= $signed(s_tdata[66:35]);
				res_x_q  <= '0;
				res_y_q  <= '0;
				res_st_q <= STAT_EMPTY;
			end
			ST_TR_MUL: begin
				case (cnt_q)
					6'd1:    accx_q <= 52'(prod_q);
					6'd2:    accx_q <= accx_q - 52'(prod_q);
					6'd3:    accy_q <= 52'(prod_q);
					6'd4:    accy_q <= accy_q + 52'(prod_q);
					default: ;
				endcase
			end
			ST_E_RDB: begin
				ax_q <= $signed(wv_rdata[31:0]);
				ay_q <= $signed(wv_rdata[63:32]);
			end
			ST_E_DIF: begin
				dx_q <= 33'($signed(wv_rdata[31:0])) - 33'(ax_q);
				dy_q <= 33'($signed(wv_rdata[63:32])) - 33'(ay_q);
				ex_q <= 33'(px_q) - 33'(ax_q);
				ey_q <= 33'(py_q) - 33'(ay_q);
			end
			ST_E_MUL: begin
				case (cnt_q)
					6'd1:    len2_q <= $unsigned(prod_q);
					6'd2:    len2_q <= len2_q + $unsigned(prod_q);
					6'd3:    dot_q  <= 67'(prod_q);
					6'd4:    dot_q  <= dot_q + 67'(prod_q);
					default: ;
				endcase
			end
			ST_E_CHK: begin
				r_q <= {1'b0, dot_q[65:0]};
				if (len2_q != '0 && !dot_q[66] && dot_q != '0 && dot_q[65:0] >= len2_q) begin
					t_q <= 17'd65536;
				end else begin
					t_q <= '0;
				end
			end
			ST_E_DIV: begin
				if (r_dbl >= {1'b0, len2_q}) begin
					r_q <= r_dbl - {1'b0, len2_q};
					t_q <= {t_q[15:0], 1'b1};
				end else begin
					r_q <= r_dbl;
					t_q <= {t_q[15:0], 1'b0};
				end
			end
			ST_E_SCL: begin
				if (cnt_q == 6'd1) cx_q <= 33'(ax_q) + scale_rnd(prod_q);
				if (cnt_q == 6'd2) cy_q <= 33'(ay_q) + scale_rnd(prod_q);
			end
			ST_E_D2: begin
				if (cnt_q == 6'd1) d2_q <= $unsigned(prod_q);
				if (cnt_q == 6'd2) d2_q <= d2_q + $unsigned(prod_q);
			end
			ST_E_CMP: begin
				res_st_q <= STAT_OK;
				if (first_q || d2_q < best_q) begin
					best_q  <= d2_q;
					res_x_q <= cx_q[31:0];
					res_y_q <= cy_q[31:0];
				end
			end
			ST_C_DIF: begin
				dx_q <= 33'(px_q) - 33'(body_x_q);
				dy_q <= 33'(py_q) - 33'(body_y_q);
			end
			ST_C_MUL: begin
				if (cnt_q == 6'd1) len2_q <= $unsigned(prod_q);
				if (cnt_q == 6'd2) begin
					sqn_q  <= {2'b00, len2_q + $unsigned(prod_q)};
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			ST_C_SQ: begin
				sqn_q <= {sqn_q[65:0], 2'b00};
				if (sq_rem >= sq_trial) begin
					rem_q  <= sq_rem - sq_trial;
					root_q <= {root_q[32:0], 1'b1};
				end else begin
					rem_q  <= sq_rem;
					root_q <= {root_q[32:0], 1'b0};
				end
			end
			ST_C_CHK: begin
				if (root_q == '0) begin
					res_x_q  <= px_q;
					res_y_q  <= py_q;
					res_st_q <= STAT_CENTER;
				end
			end
			ST_C_DVI: begin
				drem_q <= {3'b000, prod_mag[63:32]};
				dnum_q <= prod_mag[31:0];
				quo_q  <= '0;
			end
			ST_C_DV: begin
				dnum_q <= {dnum_q[30:0], 1'b0};
				if (dv_rem >= {1'b0, root_q}) begin
					drem_q <= dv_rem - {1'b0, root_q};
					quo_q  <= {quo_q[30:0], 1'b1};
				end else begin
					drem_q <= dv_rem;
					quo_q  <= {quo_q[30:0], 1'b0};
				end
			end
			ST_C_OUT: begin
				res_st_q <= STAT_OK;
				if (axis_q) begin
					res_y_q <= sat32(c_out);
				end else begin
					res_x_q <= sat32(c_out);
				end
			end
			default: ;
		endcase
	end

	`CPS_ASSERT_NXT(a_query_leaves_idle, s_acc && s_tuser == ACT_QUERY, state_q != ST_IDLE, "query item did not start work")
	`CPS_ASSERT_IMP(a_t_range, state_q == ST_E_SCL, t_q <= 17'd65536, "edge parameter above one")
	`CPS_ASSERT_NXT(a_result_loaded, state_q == ST_DONE && out_free, m_tvalid_q, "finished query lost its result")
	`CPS_ASSERT_IMP(a_edge_index, state_q == ST_E_CMP, CW'(idx_q) < n_use, "edge index beyond vertex count")
	`CPS_ASSERT_IMP(a_div_rem, state_q == ST_C_DV, drem_q < {1'b0, root_q}, "divider remainder not below distance")

endmodule
